### hw/rtl/dfe_pkg.sv
// shared types and constants for the delimited field extractor
// no dependencies; used by every module of the block except dfe_ram
`default_nettype none

package dfe_pkg;

	// value buffer geometry
	localparam int BUF_DEPTH = 32;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);

	typedef logic [ADDR_W-1:0] addr_t;

	// largest fill level, one entry stays unused
	localparam addr_t FILL_MAX = addr_t'(BUF_DEPTH - 1);

	// run command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// action codes on the input channel
	localparam logic [1:0] ACT_FEED  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_EN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_CHAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_EN   = 3'd4;

	// one run to emit: source flag and byte count (zero means empty)
	typedef struct packed {
		logic  from_read;
		addr_t len;
	} cmd_t;

	// buffer write port from the front
	typedef struct packed {
		logic       we;
		addr_t      addr;
		logic [7:0] data;
	} ram_wr_t;

	// read side control from the back
	typedef struct packed {
		logic  re;
		addr_t addr;
	} ram_rd_t;

endpackage

`default_nettype wire

### hw/rtl/dfe_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module dfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dfe_front.sv
// front part: input register, configuration registers, column tracking,
// buffer writes and run commands; depends on dfe_pkg
`default_nettype none

module dfe_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     in_action,
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic                           busy,
	input  wire logic                           cmd_full,
	output logic                                cmd_push,
	output dfe_pkg::cmd_t                       cmd,
	output dfe_pkg::ram_wr_t                    ram_wr
);

	// configuration
	logic [7:0] sep_char_q;
	logic       sep_en_q;
	logic [7:0] column_q;
	logic [7:0] stop_char_q;
	logic       stop_en_q;

	// extraction state
	logic           receiving_q;
	logic [7:0]     sep_cnt_q;
	dfe_pkg::addr_t fill_q;

	// input stage
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] byte_s1;

	logic           is_feed, is_read, is_clear, counting;
	logic [7:0]     cnt_next;
	logic           buffers, stores, stop_hit, adv;
	dfe_pkg::addr_t fill_after;

	assign cfg_ready = 1'b1;

	always_comb begin
		is_feed    = (action_s1 == dfe_pkg::ACT_FEED) && (byte_s1 != 8'd0);
		is_read    = (action_s1 == dfe_pkg::ACT_READ);
		is_clear   = (action_s1 == dfe_pkg::ACT_CLEAR);
		counting   = !receiving_q && sep_en_q;
		cnt_next   = ((byte_s1 == sep_char_q) && (sep_cnt_q != 8'hff)) ?
			sep_cnt_q + 8'd1 : sep_cnt_q;
		buffers    = is_feed && (!counting || (column_q == 8'd0));
		stores     = buffers && (fill_q < dfe_pkg::FILL_MAX);
		stop_hit   = buffers && stop_en_q && (byte_s1 == stop_char_q);
		fill_after = stores ? fill_q + dfe_pkg::addr_t'(1) : fill_q;
		// hold buffer writes while a run may still read the buffer
		adv        = valid_s1 && !(stores && busy) &&
			!((stop_hit || is_read) && cmd_full);
	end

	assign in_ready      = !valid_s1 || adv;
	assign cmd_push      = adv && (stop_hit || is_read);
	assign cmd.from_read = is_read;
	assign cmd.len       = is_read ? fill_q : fill_after;
	assign ram_wr.we     = adv && stores;
	assign ram_wr.addr   = fill_q;
	assign ram_wr.data   = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= in_action;
			byte_s1   <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_char_q  <= 8'd32;
			sep_en_q    <= 1'b1;
			column_q    <= 8'd0;
			stop_char_q <= 8'd10;
			stop_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dfe_pkg::REG_SEP_CHAR:  sep_char_q  <= cfg_data;
				dfe_pkg::REG_SEP_EN:    sep_en_q    <= cfg_data[0];
				dfe_pkg::REG_COLUMN:    column_q    <= cfg_data;
				dfe_pkg::REG_STOP_CHAR: stop_char_q <= cfg_data;
				dfe_pkg::REG_STOP_EN:   stop_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			sep_cnt_q   <= 8'd0;
			fill_q      <= '0;
		end else if (cfg_valid && (cfg_index <= dfe_pkg::REG_STOP_EN)) begin
			// a register write restarts extraction
			receiving_q <= 1'b0;
			sep_cnt_q   <= 8'd0;
			fill_q      <= '0;
		end else if (adv) begin
			if (is_clear || stop_hit) begin
				receiving_q <= 1'b0;
				sep_cnt_q   <= 8'd0;
				fill_q      <= '0;
			end else if (is_feed) begin
				if (counting) begin
					sep_cnt_q <= cnt_next;
					if (cnt_next >= column_q) begin
						receiving_q <= 1'b1;
					end
				end
				if (buffers) begin
					receiving_q <= 1'b1;
					fill_q      <= fill_after;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dfe_cmd_fifo.sv
// short queue of run commands between front and back
// depends on dfe_pkg
`default_nettype none

module dfe_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dfe_pkg::cmd_t push_cmd,
	output logic               full,
	output logic               not_empty,
	input  wire logic          pop,
	output dfe_pkg::cmd_t      head
);

	dfe_pkg::cmd_t                    mem_q [dfe_pkg::CMDQ_DEPTH];
	logic [dfe_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dfe_pkg::CMDQ_CNT_W-1:0]   count_q;

	assign full      = (count_q == dfe_pkg::CMDQ_CNT_W'(dfe_pkg::CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dfe_pkg::CMDQ_PTR_W'(dfe_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == dfe_pkg::CMDQ_PTR_W'(dfe_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dfe_back.sv
// back part: walks the buffer for each run command and drives the output
// depends on dfe_pkg
`default_nettype none

module dfe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_avail,
	input  wire dfe_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               busy,
	output dfe_pkg::ram_rd_t   ram_rd,
	input  wire logic [7:0]    ram_rdata,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic               out_from_read,
	output logic               out_empty
);

	// run sequencer
	logic           active_q;
	dfe_pkg::addr_t idx_q, len_q;
	logic           rd_flag_q;

	// ram read stage
	logic valid_s1, last_s1, rd_s1, empty_s1;

	logic issue, item_empty, item_last, s1_adv, out_load;

	always_comb begin
		out_load   = valid_s1 && (!out_valid || out_ready);
		s1_adv     = !valid_s1 || out_load;
		issue      = active_q && s1_adv;
		item_empty = (len_q == '0);
		item_last  = item_empty || (idx_q == len_q - dfe_pkg::addr_t'(1));
	end

	assign cmd_pop     = !active_q && cmd_avail;
	assign busy        = active_q || cmd_avail;
	assign ram_rd.re   = issue;
	assign ram_rd.addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd_pop) begin
			active_q <= 1'b1;
		end else if (issue && item_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			idx_q     <= '0;
			len_q     <= cmd.len;
			rd_flag_q <= cmd.from_read;
		end else if (issue) begin
			idx_q <= idx_q + dfe_pkg::addr_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1  <= item_last;
			rd_s1    <= rd_flag_q;
			empty_s1 <= item_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte      <= empty_s1 ? 8'd0 : ram_rdata;
			out_last      <= last_s1;
			out_from_read <= rd_s1;
			out_empty     <= empty_s1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/delimited_field_extractor_core.sv
// top level of the delimited field extractor: front, command queue, back and
// value buffer; depends on dfe_pkg, dfe_front, dfe_cmd_fifo, dfe_back, dfe_ram
`default_nettype none

// Picks one column out of a byte stream. Feed transactions (tuser action 0)
// carry one byte; zero bytes are ignored. Separator bytes are counted until
// column_index of them have passed, then bytes are buffered (at most
// BUF_DEPTH-1, later ones dropped) up to and including the stop byte, which
// emits the buffered value as a run of output transactions ending in tlast
// and restarts the search. Action 1 clears the search state, action 2 reads
// the current buffer out without clearing it (one transaction flagged empty,
// data zero, when nothing is buffered). Any configuration write also clears
// the search state; write configuration only while the block is idle.
// Rate: one input transaction per cycle when nothing stalls, after an input register.
// A byte that goes into the buffer waits while a run is queued or being read
// out, since the run reads the same buffer; separator counting, clears and
// reads keep flowing (the queue holds two runs beside the one being read
// out). A run of n bytes leaves at one byte per cycle while the output is
// ready, through the buffer's single read port, passing the input register,
// the run queue, the run sequencer, the buffer read and the output register.
module delimited_field_extractor_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
	input  wire logic [1:0]                    s_axis_tuser,  // [1:0] action
	// result stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // [7:0] out_byte
	output logic                               m_axis_tlast,
	output logic [1:0]                         m_axis_tuser,  // [0] from_read, [1] empty_res
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	// front to queue
	logic          cmd_push;
	dfe_pkg::cmd_t cmd_in;
	logic          cmd_full;

	// queue to back
	logic          cmd_avail;
	logic          cmd_pop;
	dfe_pkg::cmd_t cmd_head;

	// back tells the front that a run is queued or the buffer is being read
	logic busy;

	// value buffer ports
	dfe_pkg::ram_wr_t ram_wr;
	dfe_pkg::ram_rd_t ram_rd;
	logic [7:0]       ram_rdata;

	logic out_from_read, out_empty;

	dfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.ram_wr    (ram_wr)
	);

	dfe_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd_in),
		.full      (cmd_full),
		.not_empty (cmd_avail),
		.pop       (cmd_pop),
		.head      (cmd_head)
	);

	// value store, no reset: only written entries reach the output
	dfe_ram #(
		.WIDTH (8),
		.DEPTH (dfe_pkg::BUF_DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	dfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_avail     (cmd_avail),
		.cmd           (cmd_head),
		.cmd_pop       (cmd_pop),
		.busy          (busy),
		.ram_rd        (ram_rd),
		.ram_rdata     (ram_rdata),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.out_last      (m_axis_tlast),
		.out_from_read (out_from_read),
		.out_empty     (out_empty)
	);

	assign m_axis_tuser = {out_empty, out_from_read};

	// the buffer is never written while a run may still read it
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.we |-> !busy)
		else $error("buffer write while a run is pending");

	// commands are never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("run command pushed into full queue");

	// an empty result is a single zero byte closing its run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
		else $error("empty result without last or with data");

	// buffer read and write never hit the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.re |-> !ram_wr.we)
		else $error("buffer read and write in the same cycle");

endmodule

`default_nettype wire
